@@ hw/rtl/ntg_pkg.sv @@
// Shared constants, tables and elaboration-time helpers for the note tone generator.
package ntg_pkg;

  // Command kinds carried on the input user field.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Accidental codes; the unused code plays as natural.
  localparam logic [1:0] ACC_NATURAL = 2'd0;
  localparam logic [1:0] ACC_SHARP   = 2'd1;
  localparam logic [1:0] ACC_FLAT    = 2'd2;

  // Status codes reported on a start request.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_NOTE = 2'd1;
  localparam logic [1:0] STATUS_BAD_OCT  = 2'd2;
  localparam logic [1:0] STATUS_ZERO_DUR = 2'd3;

  // Field widths.
  localparam int LETTER_W = 8;
  localparam int ACC_W    = 2;
  localparam int OCT_W    = 5;
  localparam int DUR_W    = 32;
  localparam int SAMPLE_W = 16;
  localparam int STATUS_W = 2;
  localparam int AMP_W    = 15;
  localparam int MAG_W    = 15;

  // Stream data widths, padded to whole bytes.
  localparam int IN_DATA_BITS  = LETTER_W + ACC_W + OCT_W + DUR_W;
  localparam int IN_DATA_W     = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = SAMPLE_W + STATUS_W;
  localparam int OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;

  // Audio timing.
  localparam int DEF_PHASE_BITS = 32;
  localparam longint unsigned AUDIO_RATE_HZ = 48000;
  localparam int FRAMES_PER_MS = int'(AUDIO_RATE_HZ / 1000);
  localparam int FRAMES_W = DUR_W + $clog2(FRAMES_PER_MS + 1);
  localparam longint unsigned STEP_DEN = AUDIO_RATE_HZ * 1000;

  // Sine lookup: the top address bits of the phase, two of them for the quadrant.
  localparam int SINE_ADDR_BITS = 10;
  localparam int QPOS_W = SINE_ADDR_BITS - 2;
  localparam int QTAB_DEPTH = 1 << QPOS_W;

  localparam longint unsigned POLY_A = 51472;
  localparam longint unsigned POLY_B = 21024;
  localparam longint unsigned POLY_C = 2320;

  // Reset value of the amplitude register, 0.2 of full scale.
  localparam logic [AMP_W-1:0] AMP_RESET = 15'd6553;

  // Octave 9 note frequencies in milli-hertz, C9 up to B9.
  typedef longint unsigned mhz_tab_t [12];
  localparam mhz_tab_t TOP_MHZ = '{
    64'd8372018,  64'd8869844,  64'd9397273,  64'd9956063,
    64'd10548082, 64'd11175303, 64'd11839822, 64'd12543854,
    64'd13289750, 64'd14080000, 64'd14917240, 64'd15804266
  };

  // Semitone of each natural letter, A up to G.
  typedef logic [3:0] semi_tab_t [7];
  localparam semi_tab_t LETTER_SEMI = '{4'd9, 4'd11, 4'd0, 4'd2, 4'd4, 4'd5, 4'd7};

  // Rounded phase step of an octave 9 note, by long division at elaboration.
  function automatic longint unsigned top_step(longint unsigned f_mhz, int pb);
    longint unsigned q;
    longint unsigned r;
    q = f_mhz / STEP_DEN;
    r = f_mhz % STEP_DEN;
    for (int i = 0; i < pb; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= STEP_DEN) begin
        r = r - STEP_DEN;
        q = q | 64'd1;
      end
    end
    if (2 * r >= STEP_DEN) q = q + 1;
    return q;
  endfunction

  // Sine magnitude in Q15 for a quarter-wave position k (0 up to QTAB_DEPTH).
  function automatic logic [MAG_W-1:0] sine_mag(int k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned y;
    x  = longint'(k) << (17 - SINE_ADDR_BITS);
    x2 = (x * x) >> 15;
    t  = (POLY_C * x2) >> 15;
    t  = POLY_B - t;
    t  = (t * x2) >> 15;
    t  = POLY_A - t;
    y  = (t * x) >> 15;
    if (y > 64'd32767) y = 64'd32767;
    return y[MAG_W-1:0];
  endfunction

  typedef logic [MAG_W-1:0] sine_tab_t [QTAB_DEPTH];

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int k = 0; k < QTAB_DEPTH; k++) tab[k] = sine_mag(k);
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();
  // Magnitude at the quadrant edge, reached only in mirrored quadrants.
  localparam logic [MAG_W-1:0] SINE_TOP = sine_mag(QTAB_DEPTH);

endpackage

@@ hw/rtl/note_tone_generator_top.sv @@
// Top level of the note tone generator: command decode, phase accumulator and sample scaling.
//
// Usage: requests arrive on the in_ stream. in_tuser selects the kind: a start request
// validates the note letter, accidental, octave and duration, loads the phase step and
// frame count and answers with a status; a tick request returns one Q1.15 sine sample of
// the current tone scaled by the amplitude register, or zero while idle. Every request
// gives exactly one response on the out_ stream, in order. out_tlast marks the final
// sample of a tone, out_tuser marks a response that carries a tone sample.
// The amplitude is written through the cfg_ channel, which is always ready; write it
// while no request is in flight.
// A request is captured in the input register and its response in the output register,
// which drives the out_ ports. One request is taken every cycle while the receiver keeps
// up: the tone state update, the sine table lookup and the amplitude scaling all sit
// between the input register and the output register. When the receiver stalls, both
// registers hold and in_tready falls in the same cycle; no response is lost or repeated.
// Reset (rst_n low, synchronous) empties both registers, stops any tone and restores the
// amplitude to 0.2 of full scale.
module note_tone_generator_top
  import ntg_pkg::*;
#(
  parameter int PHASE_BITS = DEF_PHASE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Request stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // note_letter, accidental, octave, duration
  input  logic                  in_tuser,   // cmd
  // Response stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // sample, status
  output logic                  out_tuser,  // sample_valid
  output logic                  out_tlast,  // last_sample
  // Amplitude write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [AMP_W-1:0]      cfg_data
);

  localparam int SHIFT_W = 4;

  // Pipeline advance: everything moves when the output register is free or being taken.
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  // Amplitude register.
  logic [AMP_W-1:0] amp_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r <= AMP_RESET;
    end else if (cfg_valid) begin
      amp_r <= cfg_data;
    end
  end

  // Octave 9 phase steps, computed at elaboration.
  logic [PHASE_BITS-1:0] step_tab [12];
  for (genvar g = 0; g < 12; g++) begin : g_step
    localparam longint unsigned STEP = top_step(TOP_MHZ[g], PHASE_BITS);
    assign step_tab[g] = STEP[PHASE_BITS-1:0];
  end

  // Input register stage.
  logic                s1_valid_r;
  logic                s1_cmd_r;
  logic [LETTER_W-1:0] s1_letter_r;
  logic [ACC_W-1:0]    s1_acc_r;
  logic [OCT_W-1:0]    s1_oct_r;
  logic [DUR_W-1:0]    s1_dur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r    <= in_tuser;
      s1_letter_r <= in_tdata[LETTER_W-1:0];
      s1_acc_r    <= in_tdata[LETTER_W +: ACC_W];
      s1_oct_r    <= in_tdata[LETTER_W+ACC_W +: OCT_W];
      s1_dur_r    <= in_tdata[LETTER_W+ACC_W+OCT_W +: DUR_W];
    end
  end

  // Tone state.
  logic [PHASE_BITS-1:0] phase_acc_r, phase_acc_nxt;
  logic [PHASE_BITS-1:0] phase_step_r, phase_step_nxt;
  logic [FRAMES_W-1:0]   frames_left_r, frames_left_nxt;
  logic                  playing_r, playing_nxt;

  // Start decode: letter, accidental adjustment, range checks.
  logic [LETTER_W-1:0] up;
  logic                letter_ok;
  logic [2:0]          letter_idx;
  logic [3:0]          semi_base;
  logic [3:0]          semi;
  logic signed [OCT_W:0] oct_adj;
  logic                oct_ok;
  logic [1:0]          start_status;
  logic [SHIFT_W-1:0]  oct_shift;
  logic signed [OCT_W:0] shift_full;
  logic [FRAMES_W-1:0] frames;

  always_comb begin
    up         = s1_letter_r & 8'hDF;
    letter_ok  = (up >= 8'h41) && (up <= 8'h47);
    letter_idx = 3'(up[2:0] - 3'd1);
    semi_base  = (letter_idx < 3'd7) ? LETTER_SEMI[letter_idx] : 4'd0;
    semi       = semi_base;
    oct_adj    = {s1_oct_r[OCT_W-1], s1_oct_r};
    if (s1_acc_r == ACC_SHARP) begin
      if (semi_base == 4'd11) begin
        semi    = 4'd0;
        oct_adj = oct_adj + 6'sd1;
      end else begin
        semi = semi_base + 4'd1;
      end
    end else if (s1_acc_r == ACC_FLAT) begin
      if (semi_base == 4'd0) begin
        semi    = 4'd11;
        oct_adj = oct_adj - 6'sd1;
      end else begin
        semi = semi_base - 4'd1;
      end
    end
    oct_ok = (oct_adj >= -6'sd1) && (oct_adj <= 6'sd9);

    if (!letter_ok) begin
      start_status = STATUS_BAD_NOTE;
    end else if (!oct_ok) begin
      start_status = STATUS_BAD_OCT;
    end else if (s1_dur_r == '0) begin
      start_status = STATUS_ZERO_DUR;
    end else begin
      start_status = STATUS_OK;
    end

    shift_full = 6'sd9 - oct_adj;
    oct_shift  = shift_full[SHIFT_W-1:0];
    frames     = FRAMES_W'(s1_dur_r) * FRAMES_W'(FRAMES_PER_MS);
  end

  // Sine lookup of the current phase: quadrant, mirrored position, table read.
  logic [SINE_ADDR_BITS-1:0] sine_idx;
  logic [QPOS_W:0]           qpos;
  logic [MAG_W-1:0]          mag;

  always_comb begin
    sine_idx = phase_acc_r[PHASE_BITS-1 -: SINE_ADDR_BITS];
    if (sine_idx[QPOS_W]) begin
      qpos = (QPOS_W+1)'(QTAB_DEPTH) - {1'b0, sine_idx[QPOS_W-1:0]};
    end else begin
      qpos = {1'b0, sine_idx[QPOS_W-1:0]};
    end
    mag = qpos[QPOS_W] ? SINE_TOP : SINE_TAB[qpos[QPOS_W-1:0]];
  end

  // Per-request outcome and next tone state.
  logic             do_req;
  logic             tick_play;
  logic [MAG_W-1:0] r_mag;
  logic             r_neg;
  logic             r_valid;
  logic             r_last;
  logic [1:0]       r_status;

  always_comb begin
    do_req          = adv && s1_valid_r;
    tick_play       = (s1_cmd_r == CMD_TICK) && playing_r;
    phase_acc_nxt   = phase_acc_r;
    phase_step_nxt  = phase_step_r;
    frames_left_nxt = frames_left_r;
    playing_nxt     = playing_r;
    r_mag           = '0;
    r_neg           = 1'b0;
    r_valid         = 1'b0;
    r_last          = 1'b0;
    r_status        = STATUS_OK;
    if (s1_cmd_r == CMD_START) begin
      r_status = start_status;
      if (start_status == STATUS_OK) begin
        phase_step_nxt  = step_tab[semi] >> oct_shift;
        phase_acc_nxt   = '0;
        frames_left_nxt = frames;
        playing_nxt     = 1'b1;
      end
    end else if (tick_play) begin
      r_mag           = mag;
      r_neg           = sine_idx[SINE_ADDR_BITS-1];
      r_valid         = 1'b1;
      phase_acc_nxt   = phase_acc_r + phase_step_r;
      frames_left_nxt = frames_left_r - FRAMES_W'(frames_left_r != '0);
      if (frames_left_nxt == '0) begin
        r_last      = 1'b1;
        playing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r   <= '0;
      phase_step_r  <= '0;
      frames_left_r <= '0;
      playing_r     <= 1'b0;
    end else if (do_req) begin
      phase_acc_r   <= phase_acc_nxt;
      phase_step_r  <= phase_step_nxt;
      frames_left_r <= frames_left_nxt;
      playing_r     <= playing_nxt;
    end
  end

  // Scale by amplitude with rounding, then restore the sign.
  logic [AMP_W+MAG_W:0]  rounded;
  logic [SAMPLE_W-1:0]   scaled;
  logic [SAMPLE_W-1:0]   sample_nxt;

  always_comb begin
    rounded    = (AMP_W+MAG_W+1)'(r_mag) * (AMP_W+MAG_W+1)'(amp_r)
                 + (AMP_W+MAG_W+1)'(16384);
    scaled     = rounded[AMP_W+MAG_W -: SAMPLE_W];
    sample_nxt = r_neg ? SAMPLE_W'(16'd0 - scaled) : scaled;
  end

  // Output register.
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic [1:0]          out_status_r;
  logic                out_sval_r;
  logic                out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_sample_r <= sample_nxt;
      out_status_r <= r_status;
      out_sval_r   <= r_valid;
      out_last_r   <= r_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W-OUT_DATA_BITS)'(0), out_status_r, out_sample_r};
  assign out_tuser  = out_sval_r;
  assign out_tlast  = out_last_r;

endmodule

@@ test/tb_note_tone_generator_top.sv @@
// Self-checking testbench for the note tone generator: random and directed requests, scoreboard.
module tb_note_tone_generator_top
  import ntg_pkg::*;
();

  // Sample rate times 1000, the denominator of a milli-hertz phase step.
  localparam longint unsigned RATE_X1000 = 64'd48_000_000;
  localparam int TICKS_PER_MS = 48;
  // Polynomial sine coefficients in Q15.
  localparam longint unsigned SIN_K1 = 64'd51472;
  localparam longint unsigned SIN_K3 = 64'd21024;
  localparam int unsigned     SIN_K5 = 2320;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 4000;

  typedef struct {
    logic              cmd;
    logic [7:0]        letter;
    logic [1:0]        acc;
    logic signed [4:0] octave;
    logic [31:0]       dur_ms;
  } tone_req_t;

  typedef struct {
    logic signed [15:0] sample;
    logic               sample_valid;
    logic               last_sample;
    logic [1:0]         status;
  } tone_out_t;

  // Octave 9 note frequencies in milli-hertz, C9 up to B9.
  function automatic longint unsigned octave9_mhz(int semi);
    case (semi)
      0:  return 64'd8372018;
      1:  return 64'd8869844;
      2:  return 64'd9397273;
      3:  return 64'd9956063;
      4:  return 64'd10548082;
      5:  return 64'd11175303;
      6:  return 64'd11839822;
      7:  return 64'd12543854;
      8:  return 64'd13289750;
      9:  return 64'd14080000;
      10: return 64'd14917240;
      default: return 64'd15804266;
    endcase
  endfunction

  // Semitone of a natural letter, counted from A.
  function automatic int letter_semitone(int idx);
    case (idx)
      0: return 9;
      1: return 11;
      2: return 0;
      3: return 2;
      4: return 4;
      5: return 5;
      default: return 7;
    endcase
  endfunction

  // Rounded 32-bit phase step of an octave 9 note.
  function automatic longint unsigned octave9_step(int semi);
    return ((octave9_mhz(semi) << 32) + RATE_X1000 / 2) / RATE_X1000;
  endfunction

  // Sine magnitude in Q15 from phase bits 30 down to 22, mirrored in odd quadrants.
  function automatic longint unsigned wave_magnitude(logic [31:0] phase);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned y;
    x = longint'(phase[29:22]) << 7;
    if (phase[30]) x = 64'd32768 - x;
    x2 = (x * x) >> 15;
    t  = (SIN_K5 * x2) >> 15;
    t  = SIN_K3 - t;
    t  = (t * x2) >> 15;
    t  = SIN_K1 - t;
    y  = (t * x) >> 15;
    if (y > 64'd32767) y = 64'd32767;
    return y;
  endfunction

  // Tracks the tone state and the responses still owed by the block.
  class tone_scoreboard;
    tone_out_t        due_q[$];
    logic [AMP_W-1:0] amplitude;
    logic [31:0]      phase_acc;
    logic [31:0]      phase_step;
    longint unsigned  frames_left;
    bit               playing;
    int               fail_cnt;

    function new();
      amplitude   = AMP_RESET;
      phase_acc   = '0;
      phase_step  = '0;
      frames_left = 0;
      playing     = 1'b0;
      fail_cnt    = 0;
    endfunction

    function void set_amplitude(logic [AMP_W-1:0] value);
      amplitude = value;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // Works out the response to one accepted request and updates the tone state.
    function void note_request(tone_req_t r);
      tone_out_t       o;
      int              oct;
      int              semi;
      logic [7:0]      up;
      longint unsigned scaled;
      o = '{sample: '0, sample_valid: 1'b0, last_sample: 1'b0, status: STATUS_OK};
      if (r.cmd == CMD_START) begin
        oct = r.octave;
        semi = 0;
        up = r.letter & 8'hDF;
        // Letter first, then the adjusted octave, then the duration.
        if (up < "A" || up > "G") begin
          o.status = STATUS_BAD_NOTE;
        end else begin
          semi = letter_semitone(int'(up - "A"));
          if (r.acc == ACC_SHARP) begin
            semi++;
            if (semi == 12) begin
              semi = 0;
              oct++;
            end
          end else if (r.acc == ACC_FLAT) begin
            semi--;
            if (semi < 0) begin
              semi = 11;
              oct--;
            end
          end
          if (oct < -1 || oct > 9) o.status = STATUS_BAD_OCT;
          else if (r.dur_ms == 0) o.status = STATUS_ZERO_DUR;
        end
        // A rejected start leaves any running tone alone.
        if (o.status == STATUS_OK) begin
          phase_step  = 32'(octave9_step(semi) >> (9 - oct));
          phase_acc   = '0;
          frames_left = longint'(r.dur_ms) * TICKS_PER_MS;
          playing     = 1'b1;
        end
      end else if (playing) begin
        scaled = (wave_magnitude(phase_acc) * amplitude + 64'd16384) >> 15;
        o.sample = phase_acc[31] ? -16'(scaled) : 16'(scaled);
        o.sample_valid = 1'b1;
        phase_acc = phase_acc + phase_step;
        if (frames_left > 0) frames_left--;
        if (frames_left == 0) begin
          o.last_sample = 1'b1;
          playing = 1'b0;
        end
      end
      due_q.push_back(o);
    endfunction

    // Compares one accepted response with the oldest one owed.
    function void check_response(tone_out_t got);
      tone_out_t want;
      if (due_q.size() == 0) begin
        $error("response with no request outstanding: sample %0d", got.sample);
        fail_cnt++;
        return;
      end
      want = due_q.pop_front();
      if (got.sample !== want.sample) begin
        $error("sample: expected %0d, got %0d", want.sample, got.sample);
        fail_cnt++;
      end
      if (got.sample_valid !== want.sample_valid) begin
        $error("sample_valid: expected %0d, got %0d", want.sample_valid, got.sample_valid);
        fail_cnt++;
      end
      if (got.last_sample !== want.last_sample) begin
        $error("last_sample: expected %0d, got %0d", want.last_sample, got.last_sample);
        fail_cnt++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fail_cnt++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // note_letter, accidental, octave, duration
  logic                  in_tuser = CMD_TICK;   // cmd
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // sample, status
  logic                  out_tuser;       // sample_valid
  logic                  out_tlast;       // last_sample
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [AMP_W-1:0]      cfg_data = '0;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int sent_items     = 0;

  tone_scoreboard sb = new();

  note_tone_generator_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // Receiver backpressure.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Observe every handshake at the clock edge and feed the scoreboard.
  always @(posedge clk) begin
    tone_req_t req;
    tone_out_t rsp;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_amplitude(cfg_data);
      if (in_tvalid && in_tready) begin
        req.cmd    = in_tuser;
        req.letter = in_tdata[7:0];
        req.acc    = in_tdata[9:8];
        req.octave = in_tdata[14:10];
        req.dur_ms = in_tdata[46:15];
        sb.note_request(req);
      end
      if (out_tvalid && out_tready) begin
        rsp.sample       = out_tdata[15:0];
        rsp.status       = out_tdata[17:16];
        rsp.sample_valid = out_tuser;
        rsp.last_sample  = out_tlast;
        sb.check_response(rsp);
      end
    end
  end

  // Give up after a long stretch with no handshake anywhere.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic tone_req_t mk_start(logic [7:0] letter, logic [1:0] acc, int oct,
                                         logic [31:0] dur);
    tone_req_t r;
    r.cmd    = CMD_START;
    r.letter = letter;
    r.acc    = acc;
    r.octave = 5'(oct);
    r.dur_ms = dur;
    return r;
  endfunction

  // Any request at all; its starts are mostly ones that the block rejects.
  function automatic tone_req_t stray_request();
    tone_req_t r;
    r.cmd    = $urandom_range(1) ? CMD_TICK : CMD_START;
    r.letter = 8'($urandom);
    r.acc    = 2'($urandom);
    r.octave = 5'($urandom);
    case ($urandom_range(3))
      0:       r.dur_ms = '0;
      1:       r.dur_ms = 32'($urandom_range(1, 3));
      default: r.dur_ms = $urandom;
    endcase
    return r;
  endfunction

  // Present one request, with a random gap ahead of it, and wait until it is taken.
  task automatic send_request(input tone_req_t r);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.cmd;
    in_tdata  <= IN_DATA_W'({r.dur_ms, r.octave, r.acc, r.letter});
    do @(posedge clk); while (!in_tready);
    sent_items++;
  endtask

  task automatic write_amplitude(input logic [AMP_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending and wait until every response owed has come back. The first edge
  // lets the scoreboard take note of a request accepted at the edge just passed.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly whole tones with random content, played to their end or cut short,
  // mixed with stray requests.
  task automatic play_random(input int count);
    tone_req_t r;
    tone_req_t tick;
    int        stop_at;
    int        ticks;
    tick = '{cmd: CMD_TICK, letter: '0, acc: '0, octave: '0, dur_ms: '0};
    stop_at = sent_items + count;
    while (sent_items < stop_at) begin
      if ($urandom_range(99) < 75) begin
        r.cmd    = CMD_START;
        r.letter = 8'("A" + $urandom_range(6)) | ($urandom_range(1) ? 8'h20 : 8'h00);
        r.acc    = 2'($urandom);
        r.octave = 5'(int'($urandom_range(10)) - 1);
        r.dur_ms = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(1, 3));
        send_request(r);
        // Long tones get fewer ticks than they last and are left running.
        if (r.dur_ms > 3) ticks = $urandom_range(1, 60);
        else ticks = int'(r.dur_ms) * TICKS_PER_MS + $urandom_range(3);
        if ($urandom_range(9) == 0) ticks = $urandom_range(1, ticks);
        repeat (ticks) begin
          // The budget of this part ends the tone early when it runs out.
          if (sent_items >= stop_at) break;
          if ($urandom_range(49) == 0) send_request(stray_request());
          send_request(tick);
        end
      end else begin
        send_request(stray_request());
      end
    end
  endtask

  initial begin : stimulus
    tone_req_t        tick;
    logic [AMP_W-1:0] amp;
    tick = '{cmd: CMD_TICK, letter: '0, acc: '0, octave: '0, dur_ms: '0};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset amplitude.
    send_gap_pct   = 7;
    recv_stall_pct = 73;
    send_request(tick);                                          // idle tick
    send_request(mk_start("Z", ACC_NATURAL, 4, 1));
    send_request(mk_start(8'h40, ACC_NATURAL, 4, 1));            // just below A
    send_request(mk_start(8'h48, ACC_SHARP, 4, 1));              // just above G
    send_request(mk_start(8'h00, ACC_NATURAL, 0, 0));
    send_request(mk_start(8'hFF, ACC_FLAT, -1, 32'hFFFF_FFFF));
    send_request(mk_start("c", ACC_NATURAL, -1, 1));             // lowest octave, lower case
    send_request(tick);
    send_request(tick);
    // B sharp in octave 9 lands in octave 10 and is rejected; the tone plays on.
    send_request(mk_start("B", ACC_SHARP, 9, 5));
    send_request(tick);
    send_request(mk_start("B", ACC_SHARP, 8, 32'hFFFF_FFFF));    // C9, longest tone
    send_request(tick);
    send_request(tick);
    send_request(mk_start("C", ACC_FLAT, -1, 1));                // C flat drops below -1
    send_request(mk_start("C", ACC_FLAT, 0, 1));
    send_request(mk_start("G", 2'd3, 15, 1));                    // unused accidental code
    send_request(mk_start("d", ACC_NATURAL, -16, 1));
    send_request(mk_start("E", ACC_NATURAL, 4, 0));              // zero duration
    send_request(mk_start("q", ACC_NATURAL, 15, 0));             // letter checked first
    send_request(mk_start("A", ACC_NATURAL, 10, 0));             // octave before duration
    send_request(mk_start("g", 2'd3, 9, 1));
    send_request(tick);
    send_request(tick);

    // Random part: three idling profiles, two amplitude settings in each.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          send_gap_pct   = 7;
          recv_stall_pct = 73;
        end
        1: begin
          send_gap_pct   = 73;
          recv_stall_pct = 7;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      case (ph)
        0:       amp = '1;
        1:       amp = '0;
        3:       amp = 15'd1;
        5:       amp = '1;
        default: amp = AMP_W'($urandom);
      endcase
      wait_drained();
      write_amplitude(amp);
      play_random(150);
    end

    wait_drained();
    if (sb.fail_cnt == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
